// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 24;
  localparam int S_KEY_W   = 64;
  localparam int VALUE_W   = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOOKUP = 2'd3
  } krt_op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DUP     = 2'd2,
    STAT_MISSING = 2'd3
  } krt_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } krt_state_t;

  typedef struct packed {
    krt_status_t  status;
    logic [3:0]   entry_index;
    logic [7:0]   old_value;
    logic [4:0]   entry_count;
  } krt_result_t;

endpackage

// ===== rtl/krt_ram.sv =====
// ----------------------------------------------------------------------------
// krt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/krt_out_reg.sv =====
// ----------------------------------------------------------------------------
// krt_out_reg
// Result register on the master side of the table.
// ----------------------------------------------------------------------------
module krt_out_reg
  import krt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  krt_result_t res_in,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output krt_result_t res_out
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer: scans the key memory, appends, rewrites and shift-deletes.
// ----------------------------------------------------------------------------
module krt_ctrl
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64,
  localparam int IDX_W   = CAPACITY > 1 ? $clog2(CAPACITY) : 1,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  krt_op_t             in_op,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [VALUE_W-1:0]  in_value,
  output logic [IDX_W-1:0]    raddr,
  input  logic [KEY_BITS-1:0] key_rdata,
  input  logic [VALUE_W-1:0]  val_rdata,
  output logic [IDX_W-1:0]    waddr,
  output logic                key_we,
  output logic [KEY_BITS-1:0] key_wdata,
  output logic                val_we,
  output logic [VALUE_W-1:0]  val_wdata,
  input  logic                out_free,
  output logic                out_load,
  output krt_result_t         out_res
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  krt_state_t          state, state_next;
  krt_op_t             op, op_next;
  logic [KEY_BITS-1:0] key, key_next;
  logic [VALUE_W-1:0]  value, value_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    rd_ptr, rd_ptr_next;
  logic                pend, pend_next;
  logic [IDX_W-1:0]    pend_ptr, pend_ptr_next;
  krt_status_t         res_status, res_status_next;
  logic [IDX_W-1:0]    res_idx, res_idx_next;
  logic [VALUE_W-1:0]  res_old, res_old_next;

  logic                hit;
  logic                scan_end;
  logic [CNT_W-1:0]    rd_dst;
  logic [IDX_W+3:0]    idx_wide;
  logic [CNT_W+4:0]    cnt_wide;

  assign hit      = (state == ST_SCAN) && pend && (key_rdata == key);
  assign scan_end = (rd_ptr == count);
  assign rd_dst   = rd_ptr - CNT_W'(1);
  assign idx_wide = {4'b0, res_idx};
  assign cnt_wide = {5'b0, count};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_INSERT && count == FULL_COUNT) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (op == OP_DELETE) ? ST_SHIFT : ST_RESP;
        end else if (scan_end) begin
          state_next = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (scan_end && !pend) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op_next         = op;
    key_next        = key;
    value_next      = value;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    pend_next       = pend;
    pend_ptr_next   = pend_ptr;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    res_old_next    = res_old;
    in_ready        = 1'b0;
    raddr           = rd_ptr[IDX_W-1:0];
    waddr           = pend_ptr;
    key_we          = 1'b0;
    val_we          = 1'b0;
    key_wdata       = key;
    val_wdata       = value;
    out_load        = 1'b0;
    out_res.status      = res_status;
    out_res.entry_index = idx_wide[3:0];
    out_res.old_value   = res_old;
    out_res.entry_count = cnt_wide[4:0];
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next         = in_op;
          key_next        = in_key;
          value_next      = in_value;
          rd_ptr_next     = '0;
          pend_next       = 1'b0;
          res_status_next = STAT_FULL;
          res_idx_next    = '0;
          res_old_next    = '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_idx_next = pend_ptr;
          pend_next    = 1'b0;
          case (op)
            OP_INSERT: begin
              res_status_next = STAT_DUP;
              res_idx_next    = '0;
            end
            OP_UPDATE: begin
              val_we          = 1'b1;
              res_status_next = STAT_OK;
              res_old_next    = val_rdata;
            end
            OP_DELETE: begin
              res_status_next = STAT_OK;
              rd_ptr_next     = CNT_W'(pend_ptr) + CNT_W'(1);
            end
            OP_LOOKUP: begin
              res_status_next = STAT_OK;
              res_old_next    = val_rdata;
            end
            default: res_status_next = STAT_MISSING;
          endcase
        end else if (scan_end) begin
          pend_next = 1'b0;
          if (op == OP_INSERT) begin
            waddr           = count[IDX_W-1:0];
            key_we          = 1'b1;
            val_we          = 1'b1;
            count_next      = count + CNT_W'(1);
            res_status_next = STAT_OK;
            res_idx_next    = count[IDX_W-1:0];
          end else begin
            res_status_next = STAT_MISSING;
          end
        end else begin
          rd_ptr_next   = rd_ptr + CNT_W'(1);
          pend_next     = 1'b1;
          pend_ptr_next = rd_ptr[IDX_W-1:0];
        end
      end
      ST_SHIFT: begin
        key_wdata = key_rdata;
        val_wdata = val_rdata;
        key_we    = pend;
        val_we    = pend;
        if (!scan_end) begin
          rd_ptr_next   = rd_ptr + CNT_W'(1);
          pend_next     = 1'b1;
          pend_ptr_next = rd_dst[IDX_W-1:0];
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      rd_ptr <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    key        <= key_next;
    value      <= value_next;
    pend_ptr   <= pend_ptr_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
    res_old    <= res_old_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= {1'b0, FULL_COUNT})
    else $error("record count above capacity");

  a_count_source: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ($past(state) == ST_SCAN || $past(state) == ST_SHIFT))
    else $error("record count changed outside scan or shift");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    (key_we || val_we) |-> (state == ST_SCAN || state == ST_SHIFT))
    else $error("memory written while idle or responding");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && key_we) |-> (CNT_W'(waddr) < rd_ptr))
    else $error("shift write overtakes its read pointer");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == ST_IDLE))
    else $error("result loaded without returning to idle");

endmodule

// ===== rtl/keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table
// Linear-search table of up to CAPACITY key/value records in insertion order.
// ----------------------------------------------------------------------------
// The slave channel takes one operation per item: s_tuser carries the opcode
// (insert, update, delete, lookup), s_tdata the key and the value. The master
// channel returns exactly one result item per operation: status, position,
// old value and the record count after the operation.
// Keys and values sit in two memories with one read and one write port each.
// A search reads one record per cycle; a delete then moves each
// later record down one place per cycle. An insert into a full
// table answers without a search. The single key read port sets
// this rate; one item is in work at a time.
// The result register lets the next item be taken while a result still
// waits; if the receiver stalls, the following result holds in the sequencer
// and no further item is taken until it is loaded.
// Reset empties the table at once (count zero, no clearing pass); memory
// contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // record_key[63:0], record_value[71:64]
  input  logic [1:0]           s_tuser,  // opcode[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // status[1:0], entry_index[5:2],
                                         // old_value[13:6], entry_count[18:14]
);

  localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;

  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic [KEY_BITS-1:0] key_wdata;
  logic [VALUE_W-1:0]  val_rdata;
  logic [VALUE_W-1:0]  val_wdata;
  logic                key_we;
  logic                val_we;
  logic                out_free;
  logic                out_load;
  krt_result_t         res_in;
  krt_result_t         res_out;

  krt_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (krt_op_t'(s_tuser)),
    .in_key    (s_tdata[KEY_BITS-1:0]),
    .in_value  (s_tdata[S_KEY_W +: VALUE_W]),
    .raddr     (raddr),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata),
    .waddr     (waddr),
    .key_we    (key_we),
    .key_wdata (key_wdata),
    .val_we    (val_we),
    .val_wdata (val_wdata),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_res   (res_in)
  );

  krt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  krt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  krt_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res_in   (res_in),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_out  (res_out)
  );

  assign m_tdata = {5'b0, res_out.entry_count, res_out.old_value,
                    res_out.entry_index, res_out.status};

endmodule

// ===== verif/tb_keyed_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_record_table
// Self-checking testbench for the keyed record table.
// ----------------------------------------------------------------------------
// A short directed table runs first. It covers misses on an empty table, the
// all-zero and all-one keys, a duplicate insert and a full table, where the
// full check comes before the duplicate check. It also deletes the first, the
// last and a middle record. Random phases follow. Keys come mostly from a
// small pool and from the records held, so that hits, duplicates, full-table
// refusals and deletes with shifting all occur. The insert bias swings between
// filling and draining the table. Each accepted operation goes through a
// shadow table, and each result item is compared field by field with the
// oldest expected result. The sender and the receiver idle at random in
// several mixes. One phase holds the receiver off for a long stretch while
// operations keep coming, and the sender waits for all results between
// phases.
// ----------------------------------------------------------------------------
module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 210;
  localparam int KEY_POOL      = 20;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct {
    krt_status_t status;
    logic [3:0]  entry_index;
    logic [7:0]  old_value;
    logic [4:0]  entry_count;
  } table_result_t;

  typedef struct {
    krt_op_t       op;
    logic [63:0]   key;
    logic [7:0]    value;
    bit            typed;
    table_result_t result;
  } op_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;  // record_key[63:0], record_value[71:64]
  logic [1:0]           s_tuser  = '0;  // opcode[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // status[1:0], entry_index[5:2],
                                        // old_value[13:6], entry_count[18:14]

  keyed_record_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [63:0]   stored_keys   [TABLE_DEPTH];
  logic [7:0]    stored_values [TABLE_DEPTH];
  int            stored_count = 0;
  table_result_t pending_results [$];
  op_row_t       directed_rows [$];
  logic [63:0]   key_pool [KEY_POOL];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_start     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int result_no      = 0;

  int phase_send_idle  [RANDOM_PHASES] = '{0, 56, 0, 15, 0, 56, 0, 15};
  int phase_recv_stall [RANDOM_PHASES] = '{0, 0, 56, 15, 0, 0, 56, 15};
  int phase_insert_pct [RANDOM_PHASES] = '{70, 20, 50, 70, 45, 70, 20, 45};
  bit phase_long_hold  [RANDOM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0};

  function automatic int find_key(logic [63:0] key);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t apply_table_op(krt_op_t op, logic [63:0] key,
                                                   logic [7:0] value);
    table_result_t res;
    int            pos;
    res.status      = STAT_OK;
    res.entry_index = '0;
    res.old_value   = '0;
    pos = find_key(key);
    if (op == OP_INSERT) begin
      if (stored_count >= TABLE_DEPTH) begin
        res.status = STAT_FULL;
      end else if (pos >= 0) begin
        res.status = STAT_DUP;
      end else begin
        res.entry_index = stored_count[3:0];
        stored_keys[stored_count]   = key;
        stored_values[stored_count] = value;
        stored_count++;
      end
    end else if (pos < 0) begin
      res.status = STAT_MISSING;
    end else begin
      res.entry_index = pos[3:0];
      case (op)
        OP_UPDATE: begin
          res.old_value      = stored_values[pos];
          stored_values[pos] = value;
        end
        OP_DELETE: begin
          for (int i = pos; i < stored_count - 1; i++) begin
            stored_keys[i]   = stored_keys[i + 1];
            stored_values[i] = stored_values[i + 1];
          end
          stored_count--;
        end
        default: begin
          res.old_value = stored_values[pos];
        end
      endcase
    end
    res.entry_count = stored_count[4:0];
    return res;
  endfunction

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 12 && stored_count > 0) return stored_keys[$urandom_range(stored_count - 1)];
    if (r < 18) return {$urandom, $urandom};
    return key_pool[$urandom_range(KEY_POOL - 1)];
  endfunction

  function automatic krt_op_t pick_op(int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct) return OP_INSERT;
    r = $urandom_range(2);
    if (r == 0) return OP_UPDATE;
    if (r == 1) return OP_DELETE;
    return OP_LOOKUP;
  endfunction

  task automatic add_row(krt_op_t op, logic [63:0] key, logic [7:0] value, bit typed,
                         krt_status_t status, logic [3:0] entry_index,
                         logic [7:0] old_value, logic [4:0] entry_count);
    op_row_t row;
    row.op                 = op;
    row.key                = key;
    row.value              = value;
    row.typed              = typed;
    row.result.status      = status;
    row.result.entry_index = entry_index;
    row.result.old_value   = old_value;
    row.result.entry_count = entry_count;
    directed_rows.push_back(row);
  endtask

  // Called just after an edge; leaves the item accepted at the current edge.
  task automatic offer_item(krt_op_t op, logic [63:0] key, logic [7:0] value, bit typed,
                            table_result_t typed_result);
    table_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {value, key};
    do @(posedge clk); while (!s_tready);
    predicted = apply_table_op(op, key, value);
    if (typed) pending_results.push_back(typed_result);
    else pending_results.push_back(predicted);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_start) begin
      hold_seen <= hold_start;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    table_result_t got;
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = krt_status_t'(m_tdata[1:0]);
      got.entry_index = m_tdata[5:2];
      got.old_value   = m_tdata[13:6];
      got.entry_count = m_tdata[18:14];
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d unexpected: status %0d index %0d old %0h count %0d",
                   result_no, got.status, got.entry_index, got.old_value,
                   got.entry_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.entry_index != want.entry_index ||
            got.old_value != want.old_value || got.entry_count != want.entry_count) begin
          if (mismatches < 10)
            $display("result %0d: want status %0d index %0d old %0h count %0d, got %0d %0d %0h %0d",
                     result_no, want.status, want.entry_index, want.old_value,
                     want.entry_count, got.status, got.entry_index, got.old_value,
                     got.entry_count);
          mismatches++;
        end
      end
      result_no++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_record_table: mismatch");
      $finish;
    end
  end

  initial begin
    table_result_t unused;
    unused = '{STAT_OK, 4'd0, 8'd0, 5'd0};

    add_row(OP_LOOKUP, 64'h5, 8'h00, 1, STAT_MISSING, 4'd0, 8'h00, 5'd0);
    add_row(OP_UPDATE, 64'h5, 8'h33, 1, STAT_MISSING, 4'd0, 8'h00, 5'd0);
    add_row(OP_DELETE, 64'h5, 8'h00, 1, STAT_MISSING, 4'd0, 8'h00, 5'd0);
    add_row(OP_INSERT, 64'h0, 8'h00, 1, STAT_OK, 4'd0, 8'h00, 5'd1);
    add_row(OP_INSERT, '1, 8'hFF, 1, STAT_OK, 4'd1, 8'h00, 5'd2);
    add_row(OP_INSERT, 64'h0, 8'h01, 1, STAT_DUP, 4'd0, 8'h00, 5'd2);
    add_row(OP_UPDATE, '1, 8'h00, 1, STAT_OK, 4'd1, 8'hFF, 5'd2);
    add_row(OP_LOOKUP, 64'h0, 8'hA5, 1, STAT_OK, 4'd0, 8'h00, 5'd2);
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      add_row(OP_INSERT, 64'h1000 + i, 8'(8'h40 + i), 1, STAT_OK, 4'(i + 2), 8'h00,
              5'(i + 3));
    add_row(OP_INSERT, '1, 8'h11, 1, STAT_FULL, 4'd0, 8'h00, 5'd16);
    add_row(OP_DELETE, 64'h0, 8'h00, 1, STAT_OK, 4'd0, 8'h00, 5'd15);
    add_row(OP_DELETE, 64'h100D, 8'h00, 0, STAT_OK, 4'd0, 8'h00, 5'd0);
    add_row(OP_DELETE, 64'h1005, 8'h00, 0, STAT_OK, 4'd0, 8'h00, 5'd0);
    add_row(OP_LOOKUP, 64'h1008, 8'h00, 0, STAT_OK, 4'd0, 8'h00, 5'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                 directed_rows[i].typed, directed_rows[i].result);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (pending_results.size() != 0);
      send_idle_pct  = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
      if (phase_long_hold[p]) hold_start <= hold_start + 1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_item(pick_op(phase_insert_pct[p]), pick_key(), 8'($urandom_range(255)), 0,
                   unused);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("keyed_record_table: match");
    end else begin
      $display("keyed_record_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/krt_pkg.sv
rtl/krt_ram.sv
rtl/krt_out_reg.sv
rtl/krt_ctrl.sv
rtl/keyed_record_table.sv
verif/tb_keyed_record_table.sv
